### rtl/ctsb_pkg.sv
// Package for the clipped tile stamp blitter.
// Holds the default sizes, action codes, register indexes and field widths.
// It depends on nothing.
package ctsb_pkg;

    localparam int DEF_MAX_TILES   = 64;
    localparam int DEF_MAX_EDGE    = 16;
    localparam int DEF_SPAN_PIXELS = 8;
    localparam int MAX_RESULTS     = 32;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 64;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 104;
    localparam int COORD_W = 20;

    typedef enum logic [2:0] {
        ACT_DRAW       = 3'd0,
        ACT_LOAD_PIXEL = 3'd1,
        ACT_LOAD_MAP   = 3'd2,
        ACT_LOAD_FLAG  = 3'd3,
        ACT_LOAD_REMAP = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        REG_TILE_WIDTH  = 3'd0,
        REG_TILE_HEIGHT = 3'd1,
        REG_TILE_COUNT  = 3'd2,
        REG_DEST_PITCH  = 3'd3,
        REG_CLIP_LEFT   = 3'd4,
        REG_CLIP_TOP    = 3'd5,
        REG_CLIP_SPAN_X = 3'd6,
        REG_CLIP_SPAN_Y = 3'd7
    } reg_index_t;

endpackage

### rtl/ctsb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Uses no package.
module ctsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/clipped_tile_stamp_blitter_unit.sv
// Top level of the clipped tile stamp blitter.
// Depends on ctsb_pkg and ctsb_ram.
//
// Use: the s_ channel carries one transaction per action. Loads fill the tile
// pixel, tile map, transparency flag and remap stores. A draw translates the
// tile number through the map, checks it against the tile count, clips it if
// asked and emits destination writes of up to SPAN_PIXELS pixels on the m_
// channel, row by row, with tlast on the final write of the draw.
// The cfg_ channel writes the eight configuration registers; it is always ready.
// The user must write registers only between draws; the block itself does not
// enforce this. A draw looks up the map, checks the tile and sets up the clipped
// bounds, then for every span of a row reads the pixel store one byte per cycle
// through a two-deep read pipeline (pixel store, then remap table) and forms the
// span's write. s_tready is high only between draws. One write is held back so
// that the final write can be marked; it leaves when the next write is found or
// the draw ends. When the receiver stalls, the block waits at the end of a span
// until the output register is free. Reset loads the register defaults and
// empties the output; the stores are not cleared.
module clipped_tile_stamp_blitter_unit
    import ctsb_pkg::*;
#(
    parameter int MAX_TILES   = DEF_MAX_TILES,
    parameter int MAX_EDGE    = DEF_MAX_EDGE,
    parameter int SPAN_PIXELS = DEF_SPAN_PIXELS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // load_index[13:0], load_value[21:14], tile_number[29:22], pos_x[45:30],
    // pos_y[61:46], use_remap[62], clip_enable[63]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // action[2:0]
    input  logic [S_USER_W-1:0]   s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // dest_offset[31:0], pixels[95:32], byte_mask[103:96]
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast
);
    localparam int PIX_DEPTH = MAX_TILES * MAX_EDGE * MAX_EDGE;
    localparam int PA_W = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int FA_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int N_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAP, ST_CHK, ST_SETUP, ST_SETUP2, ST_ROW,
        ST_ISSUE, ST_DRAIN, ST_SPAN, ST_FLUSH
    } state_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    state_t state_reg;
    logic [4:0]  tw_cfg_reg, th_cfg_reg;
    logic [6:0]  count_cfg_reg;
    logic [15:0] pitch_reg, left_reg, top_reg, span_x_reg, span_y_reg;

    logic signed [15:0] px_reg, py_reg;
    logic        remap_reg, clip_reg, skip_reg;
    logic [7:0]  idx_reg;
    coord_t      xs_reg, ys_reg, x0_reg, x1_reg, y0_reg, y1_reg, y_reg, cs_reg;
    logic [8:0]  twth_reg;
    logic [PA_W-1:0] base_reg, row_addr_reg;
    logic [5:0]  col_reg;
    logic [2:0]  k_reg;
    logic [31:0] row_base_reg;
    logic        p1_reg, p2_reg;
    logic [2:0]  k1_reg, k2_reg;
    logic [7:0]  pix2_reg;
    logic [63:0] acc_pix_reg;
    logic [7:0]  acc_mask_reg;
    logic [N_W-1:0] n_reg;
    logic        pend_v_reg;
    logic [M_DATA_W-1:0] pend_data_reg;
    logic        m_valid_reg, m_last_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [4:0] tw_eff, th_eff;
    logic [8:0] count_eff;
    logic       s_acc;
    action_t    act;
    logic [13:0] li;
    logic [7:0]  lv;

    assign tw_eff = (tw_cfg_reg > 5'(MAX_EDGE)) ? 5'(MAX_EDGE) : tw_cfg_reg;
    assign th_eff = (th_cfg_reg > 5'(MAX_EDGE)) ? 5'(MAX_EDGE) : th_cfg_reg;
    assign count_eff = ({2'b0, count_cfg_reg} > 9'(MAX_TILES)) ? 9'(MAX_TILES)
                                                              : {2'b0, count_cfg_reg};
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc = s_tvalid && s_tready;
    assign act = action_t'(s_tuser);
    assign li = s_tdata[13:0];
    assign lv = s_tdata[21:14];
    assign cfg_ready = 1'b1;

    logic [7:0] map_q, remap_q, pix_q;
    logic [0:0] flag_q;
    logic [PA_W-1:0] pix_raddr;

    assign pix_raddr = row_addr_reg + PA_W'(col_reg) + PA_W'(k_reg);

    ctsb_ram #(.WIDTH(8), .DEPTH(PIX_DEPTH), .AW(PA_W)) u_pix (
        .aclk(aclk),
        .we(s_acc && act == ACT_LOAD_PIXEL && 32'(li) < PIX_DEPTH),
        .waddr(PA_W'(li)), .wdata(lv), .raddr(pix_raddr), .rdata(pix_q)
    );
    ctsb_ram #(.WIDTH(8), .DEPTH(256), .AW(8)) u_map (
        .aclk(aclk),
        .we(s_acc && act == ACT_LOAD_MAP && li < 14'd256),
        .waddr(li[7:0]), .wdata(lv), .raddr(s_tdata[29:22]), .rdata(map_q)
    );
    ctsb_ram #(.WIDTH(1), .DEPTH(MAX_TILES), .AW(FA_W)) u_flag (
        .aclk(aclk),
        .we(s_acc && act == ACT_LOAD_FLAG && 32'(li) < MAX_TILES),
        .waddr(FA_W'(li)), .wdata(lv[0]), .raddr(FA_W'(map_q)), .rdata(flag_q)
    );
    ctsb_ram #(.WIDTH(8), .DEPTH(256), .AW(8)) u_remap (
        .aclk(aclk),
        .we(s_acc && act == ACT_LOAD_REMAP && li < 14'd256),
        .waddr(li[7:0]), .wdata(lv), .raddr(pix_q), .rdata(remap_q)
    );

    coord_t left_c, top_c, px_c, py_c, xs_c, ys_c, x0_c, x1_c, y0_c, y1_c;
    coord_t xe_c, ye_c, xl_c, yl_c;
    always_comb begin
        left_c = COORD_W'($signed(left_reg));
        top_c = COORD_W'($signed(top_reg));
        px_c = COORD_W'(px_reg);
        py_c = COORD_W'(py_reg);
        xs_c = clip_reg ? left_c + px_c : px_c;
        ys_c = clip_reg ? top_c + py_c : py_c;
        xe_c = xs_c + coord_t'({15'd0, tw_eff});
        ye_c = ys_c + coord_t'({15'd0, th_eff});
        xl_c = left_c + coord_t'({4'd0, span_x_reg});
        yl_c = top_c + coord_t'({4'd0, span_y_reg});
        x0_c = (clip_reg && left_c > xs_c) ? left_c : xs_c;
        y0_c = (clip_reg && top_c > ys_c) ? top_c : ys_c;
        x1_c = (clip_reg && xl_c < xe_c) ? xl_c : xe_c;
        y1_c = (clip_reg && yl_c < ye_c) ? yl_c : ye_c;
    end

    coord_t cur_c;
    logic last_issue, have_write, out_free;
    logic [7:0] v_c;
    logic [M_DATA_W-1:0] new_data;
    always_comb begin
        cur_c = cs_reg + coord_t'({17'd0, k_reg});
        last_issue = (k_reg == 3'(SPAN_PIXELS - 1)) || (cur_c + coord_t'(1) >= x1_reg);
        have_write = (acc_mask_reg != 8'd0) && (n_reg < N_W'(MAX_RESULTS));
        out_free = !m_valid_reg || m_tready;
        v_c = remap_reg ? remap_q : pix2_reg;
        new_data = {acc_mask_reg, acc_pix_reg, row_base_reg + 32'(cs_reg)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tw_cfg_reg <= 5'd16;
            th_cfg_reg <= 5'd16;
            count_cfg_reg <= 7'd0;
            pitch_reg <= 16'd640;
            left_reg <= 16'd0;
            top_reg <= 16'd0;
            span_x_reg <= 16'd640;
            span_y_reg <= 16'd400;
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
            pend_v_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            n_reg <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (reg_index_t'(cfg_index))
                    REG_TILE_WIDTH:  tw_cfg_reg <= cfg_data[4:0];
                    REG_TILE_HEIGHT: th_cfg_reg <= cfg_data[4:0];
                    REG_TILE_COUNT:  count_cfg_reg <= cfg_data[6:0];
                    REG_DEST_PITCH:  pitch_reg <= cfg_data;
                    REG_CLIP_LEFT:   left_reg <= cfg_data;
                    REG_CLIP_TOP:    top_reg <= cfg_data;
                    REG_CLIP_SPAN_X: span_x_reg <= cfg_data;
                    REG_CLIP_SPAN_Y: span_y_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            p1_reg <= (state_reg == ST_ISSUE);
            k1_reg <= k_reg;
            p2_reg <= p1_reg;
            k2_reg <= k1_reg;
            pix2_reg <= pix_q;
            if (p2_reg && !(skip_reg && v_c == 8'd0)) begin
                acc_pix_reg[k2_reg*8 +: 8] <= v_c;
                acc_mask_reg[k2_reg] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && act == ACT_DRAW) begin
                        px_reg <= s_tdata[45:30];
                        py_reg <= s_tdata[61:46];
                        remap_reg <= s_tdata[62];
                        clip_reg <= s_tdata[63];
                        state_reg <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    idx_reg <= map_q;
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    skip_reg <= remap_reg || flag_q[0];
                    xs_reg <= xs_c;
                    ys_reg <= ys_c;
                    x0_reg <= x0_c;
                    x1_reg <= x1_c;
                    y0_reg <= y0_c;
                    y1_reg <= y1_c;
                    twth_reg <= 9'(tw_eff * th_eff);
                    n_reg <= '0;
                    if ({1'b0, idx_reg} >= count_eff || tw_eff == 5'd0 || th_eff == 5'd0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    base_reg <= PA_W'(idx_reg * twth_reg);
                    if (x1_reg <= x0_reg || y1_reg <= y0_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_SETUP2;
                    end
                end
                ST_SETUP2: begin
                    row_addr_reg <= base_reg + PA_W'(5'(y0_reg - ys_reg) * tw_eff);
                    y_reg <= y0_reg;
                    state_reg <= ST_ROW;
                end
                ST_ROW: begin
                    row_base_reg <= 32'($signed(y_reg) * $signed({1'b0, pitch_reg}));
                    cs_reg <= x0_reg;
                    col_reg <= 6'(x0_reg - xs_reg);
                    k_reg <= 3'd0;
                    acc_pix_reg <= 64'd0;
                    acc_mask_reg <= 8'd0;
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    if (last_issue) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + 3'd1;
                    end
                end
                ST_DRAIN: begin
                    if (!p1_reg && !p2_reg) begin
                        state_reg <= ST_SPAN;
                    end
                end
                ST_SPAN: begin
                    if (!(have_write && pend_v_reg && !out_free)) begin
                        if (have_write) begin
                            if (pend_v_reg) begin
                                m_valid_reg <= 1'b1;
                                m_data_reg <= pend_data_reg;
                                m_last_reg <= 1'b0;
                            end
                            pend_v_reg <= 1'b1;
                            pend_data_reg <= new_data;
                            n_reg <= n_reg + N_W'(1);
                        end
                        acc_pix_reg <= 64'd0;
                        acc_mask_reg <= 8'd0;
                        k_reg <= 3'd0;
                        if (cs_reg + coord_t'(SPAN_PIXELS) < x1_reg) begin
                            cs_reg <= cs_reg + coord_t'(SPAN_PIXELS);
                            col_reg <= col_reg + 6'(SPAN_PIXELS);
                            state_reg <= ST_ISSUE;
                        end else if (y_reg + coord_t'(1) < y1_reg) begin
                            y_reg <= y_reg + coord_t'(1);
                            row_addr_reg <= row_addr_reg + PA_W'(tw_eff);
                            state_reg <= ST_ROW;
                        end else begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!pend_v_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg <= pend_data_reg;
                        m_last_reg <= 1'b1;
                        pend_v_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;
endmodule

### rtl/ctsb_checker.sv
// Port-level checker for the clipped tile stamp blitter, bound to its top level.
// Depends on ctsb_pkg.
module ctsb_checker
    import ctsb_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_ready,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_USER_W-1:0]   s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic                  m_tlast
);
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port not ready");
    a_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_DRAW |=> !s_tready)
        else $error("input taken right after a draw");
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != ACT_DRAW |=> s_tready)
        else $error("load transaction left the block busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");
endmodule

bind clipped_tile_stamp_blitter_unit ctsb_checker u_ctsb_checker (
    .aclk(aclk), .aresetn(aresetn), .cfg_ready(cfg_ready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

### verif/tb.sv
// Self-checking testbench for clipped_tile_stamp_blitter_unit.
// Depends on ctsb_pkg and the blitter RTL; it fills the part of each store that
// draws reach, then sends draws and loads under several register settings.
module tb;
    import ctsb_pkg::*;

    localparam logic [2:0] ACT_SPARE = 3'd5;
    localparam int PIX_DEPTH = DEF_MAX_TILES * DEF_MAX_EDGE * DEF_MAX_EDGE;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 350;
    localparam int HOLD_CYCLES = 600;
    localparam int PRE_PIX = 128;
    localparam int PRE_MAP = 16;
    localparam int PRE_FLAG = 8;
    localparam int PRE_REMAP = 32;

    typedef struct packed {
        logic [2:0]  act;
        logic [63:0] data;
    } blit_cmd_t;

    typedef struct packed {
        logic [31:0] offset;
        logic [63:0] pixels;
        logic [7:0]  mask;
        logic        last;
    } dest_write_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic m_tlast;

    clipped_tile_stamp_blitter_unit dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    logic [7:0] pix_store [PIX_DEPTH];
    logic [7:0] map_store [256];
    logic       flag_store [DEF_MAX_TILES];
    logic [7:0] remap_store [256];
    logic [4:0] r_width = 5'd16;
    logic [4:0] r_height = 5'd16;
    logic [6:0] r_count = 7'd0;
    logic [15:0] r_pitch = 16'd640;
    logic [15:0] r_left = 16'd0;
    logic [15:0] r_top = 16'd0;
    logic [15:0] r_span_x = 16'd640;
    logic [15:0] r_span_y = 16'd400;

    blit_cmd_t   cmd_queue[$];
    blit_cmd_t   cur_cmd;
    dest_write_t write_queue[$];
    int n_pushed = 0;
    int n_taken = 0;
    int mismatches = 0;
    int cyc = 0;
    int quiet_lo = 0;
    int quiet_hi = 0;
    int hold_at = 1 << 30;
    int hold_cnt = 0;
    int quiet_cnt = 0;
    int rand_w = 1;
    int rand_h = 1;
    bit s_done = 0;

    function automatic bit idle_now();
        if (cyc >= quiet_lo && cyc < quiet_hi)
            return 0;
        return $urandom_range(0, 99) < 34;
    endfunction

    // Map entries point at tile 0, tile 1 or past any tile count.
    function automatic int safe_tile();
        return $urandom_range(0, 2) == 0 ? $urandom_range(64, 255) : $urandom_range(0, 1);
    endfunction

    // Pixel values stay inside the written part of the remap table.
    function automatic int pix_val();
        return $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, PRE_REMAP - 1);
    endfunction

    task automatic predict_draw(input logic [63:0] d);
        longint tw, th, cnt, idx, px, py, xs, ys, x0, x1, y0, y1;
        longint left, top, len, y, cs, k, c, addr;
        bit remap, skip_zero;
        logic [7:0] v;
        dest_write_t wr;
        dest_write_t found[$];
        tw = r_width > DEF_MAX_EDGE ? DEF_MAX_EDGE : r_width;
        th = r_height > DEF_MAX_EDGE ? DEF_MAX_EDGE : r_height;
        cnt = r_count > DEF_MAX_TILES ? DEF_MAX_TILES : r_count;
        idx = map_store[d[29:22]];
        px = longint'($signed(d[45:30]));
        py = longint'($signed(d[61:46]));
        remap = d[62];
        if (idx >= cnt || tw == 0 || th == 0)
            return;
        skip_zero = remap || flag_store[idx];
        if (d[63]) begin
            left = longint'($signed(r_left));
            top = longint'($signed(r_top));
            xs = left + px;
            ys = top + py;
            x0 = xs > left ? xs : left;
            x1 = (xs + tw < left + longint'(r_span_x)) ? xs + tw : left + longint'(r_span_x);
            y0 = ys > top ? ys : top;
            y1 = (ys + th < top + longint'(r_span_y)) ? ys + th : top + longint'(r_span_y);
            if (x1 <= x0 || y1 <= y0)
                return;
        end else begin
            xs = px;
            ys = py;
            x0 = px;
            x1 = px + tw;
            y0 = py;
            y1 = py + th;
        end
        for (y = y0; y < y1; y++) begin
            for (cs = x0; cs < x1; cs += DEF_SPAN_PIXELS) begin
                len = (x1 - cs < DEF_SPAN_PIXELS) ? x1 - cs : DEF_SPAN_PIXELS;
                wr = '0;
                for (k = 0; k < len; k++) begin
                    c = cs + k - xs;
                    addr = (idx * tw * th + (y - ys) * tw + c) % PIX_DEPTH;
                    v = pix_store[addr];
                    if (remap)
                        v = remap_store[v];
                    if (!(skip_zero && v == 8'd0)) begin
                        wr.pixels[8*k +: 8] = v;
                        wr.mask[k] = 1'b1;
                    end
                end
                if (wr.mask != 8'd0 && found.size() < MAX_RESULTS) begin
                    wr.offset = 32'(y * longint'(r_pitch) + cs);
                    found.push_back(wr);
                end
            end
        end
        if (found.size() > 0)
            found[found.size()-1].last = 1'b1;
        foreach (found[i])
            write_queue.push_back(found[i]);
    endtask

    task automatic apply_cmd(input blit_cmd_t cmd);
        logic [13:0] li;
        logic [7:0] lv;
        li = cmd.data[13:0];
        lv = cmd.data[21:14];
        case (cmd.act)
            ACT_DRAW:       predict_draw(cmd.data);
            ACT_LOAD_PIXEL: pix_store[li] = lv;
            ACT_LOAD_MAP:   if (li < 256) map_store[li] = lv;
            ACT_LOAD_FLAG:  if (li < DEF_MAX_TILES) flag_store[li] = lv[0];
            ACT_LOAD_REMAP: if (li < 256) remap_store[li] = lv;
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        cyc++;
        if (aresetn && s_tvalid && s_tready) begin
            apply_cmd(cur_cmd);
            n_taken++;
            s_done = 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (write_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected write: offset %h pixels %h mask %h last %b",
                             m_tdata[31:0], m_tdata[95:32], m_tdata[103:96], m_tlast);
            end else begin
                dest_write_t exp_wr;
                exp_wr = write_queue.pop_front();
                if (m_tdata[31:0] !== exp_wr.offset || m_tdata[95:32] !== exp_wr.pixels ||
                    m_tdata[103:96] !== exp_wr.mask || m_tlast !== exp_wr.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("write mismatch: expected %h %h %h %b, got %h %h %h %b",
                                 exp_wr.offset, exp_wr.pixels, exp_wr.mask, exp_wr.last,
                                 m_tdata[31:0], m_tdata[95:32], m_tdata[103:96], m_tlast);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cnt = 0;
        else if (aresetn)
            quiet_cnt++;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_done)) begin
            s_done = 0;
            if (cmd_queue.size() > 0 && !idle_now()) begin
                cur_cmd = cmd_queue.pop_front();
                s_tuser <= cur_cmd.act;
                s_tdata <= cur_cmd.data;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_cnt == 0 && n_taken >= hold_at) begin
            hold_cnt = HOLD_CYCLES;
            hold_at = 1 << 30;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && !idle_now();
        end
    end

    task automatic cfg_write(input reg_index_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TILE_WIDTH:  r_width = val[4:0];
            REG_TILE_HEIGHT: r_height = val[4:0];
            REG_TILE_COUNT:  r_count = val[6:0];
            REG_DEST_PITCH:  r_pitch = val;
            REG_CLIP_LEFT:   r_left = val;
            REG_CLIP_TOP:    r_top = val;
            REG_CLIP_SPAN_X: r_span_x = val;
            REG_CLIP_SPAN_Y: r_span_y = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] cnt, input logic [15:0] pitch,
                            input logic [15:0] left, input logic [15:0] top,
                            input logic [15:0] sx, input logic [15:0] sy);
        cfg_write(REG_TILE_WIDTH, w);
        cfg_write(REG_TILE_HEIGHT, h);
        cfg_write(REG_TILE_COUNT, cnt);
        cfg_write(REG_DEST_PITCH, pitch);
        cfg_write(REG_CLIP_LEFT, left);
        cfg_write(REG_CLIP_TOP, top);
        cfg_write(REG_CLIP_SPAN_X, sx);
        cfg_write(REG_CLIP_SPAN_Y, sy);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send(input logic [2:0] act, input logic [63:0] data);
        blit_cmd_t cmd;
        cmd.act = act;
        cmd.data = data;
        cmd_queue.push_back(cmd);
        n_pushed++;
    endtask

    task automatic send_load(input logic [2:0] act, input int idx, input int val);
        send(act, {42'd0, 8'(val), 14'(idx)});
    endtask

    task automatic send_draw(input int tile, input int x, input int y,
                             input bit remap, input bit clip);
        send(ACT_DRAW, {clip, remap, 16'(y), 16'(x), 8'(tile), 8'($urandom), 14'($urandom)});
    endtask

    task automatic drain();
        do @(posedge aclk); while (n_taken != n_pushed || write_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic int pick_pos(input bit clip);
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 65535) - 32768;
            1: return clip ? 32'(-$signed(16'(r_span_x))) : -32768;
            default: return $urandom_range(0, 60) - 20;
        endcase
    endfunction

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            send_draw($urandom_range(0, PRE_MAP - 1), pick_pos(1'b1), pick_pos(1'b1),
                      1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
        else if (sel < 65)
            send_load(ACT_LOAD_PIXEL, $urandom_range(0, PIX_DEPTH - 1), pix_val());
        else if (sel < 75)
            send_load(ACT_LOAD_MAP, $urandom_range(0, 3) == 0 ? $urandom_range(0, 16383)
                      : $urandom_range(0, 255), safe_tile());
        else if (sel < 85)
            send_load(ACT_LOAD_FLAG, $urandom_range(0, 3) == 0 ? $urandom_range(0, 16383)
                      : $urandom_range(0, 63), $urandom_range(0, 255));
        else if (sel < 95)
            send_load(ACT_LOAD_REMAP, $urandom_range(0, 3) == 0 ? $urandom_range(0, 16383)
                      : $urandom_range(0, 255), $urandom_range(0, 255));
        else
            send(ACT_SPARE + 3'($urandom_range(0, 2)), {$urandom, $urandom});
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Draws reach only two tiles of at most 64 pixels, map entries 0 to 15
        // and 255, and remap entries below 32; all of these are written first.
        for (int i = 0; i < PRE_PIX; i++)
            send_load(ACT_LOAD_PIXEL, i, pix_val());
        for (int i = 0; i < PRE_MAP; i++)
            send_load(ACT_LOAD_MAP, i, safe_tile());
        send_load(ACT_LOAD_MAP, 255, safe_tile());
        for (int i = 0; i < PRE_FLAG; i++)
            send_load(ACT_LOAD_FLAG, i, $urandom_range(0, 255));
        for (int i = 0; i < PRE_REMAP; i++)
            send_load(ACT_LOAD_REMAP, i, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255));
        send_draw(0, 0, 0, 1'b0, 1'b0);
        drain();

        set_regs(16'd31, 16'd4, 16'd127, 16'd65535, 16'h8000, 16'h8000, 16'd65535, 16'd0);
        send_load(ACT_LOAD_MAP, 0, 1);
        send_load(ACT_LOAD_MAP, 1, 70);
        send_load(ACT_LOAD_MAP, 255, 0);
        send_load(ACT_LOAD_FLAG, 1, 1);
        send_load(ACT_LOAD_FLAG, 63, 0);
        send_load(ACT_LOAD_MAP, 16383, 255);
        send_load(ACT_LOAD_FLAG, 64, 1);
        send_load(ACT_LOAD_REMAP, 300, 7);
        send(ACT_SPARE, '1);
        send(ACT_SPARE + 3'd2, '1);
        send_draw(0, 0, 0, 1'b0, 1'b0);
        send_draw(0, 0, 0, 1'b1, 1'b1);
        send_draw(255, 32767, 32767, 1'b0, 1'b0);
        send_draw(255, -32768, -32768, 1'b1, 1'b0);
        send_draw(1, 0, 0, 1'b0, 1'b0);
        drain();

        set_regs(16'd8, 16'd8, 16'd64, 16'd640, 16'd0, 16'd0, 16'd40, 16'd30);
        send_draw(0, -5, -9, 1'b1, 1'b1);
        send_draw(0, 30, 20, 1'b0, 1'b1);
        send_draw(255, 40, 0, 1'b0, 1'b1);
        send_draw(255, -16, 3, 1'b1, 1'b1);
        send_draw(0, 3, 5, 1'b1, 1'b0);
        send_draw(255, 7, 2, 1'b0, 1'b1);
        drain();

        hold_at = n_pushed + 6;
        quiet_lo = cyc + 2000;
        quiet_hi = cyc + 9000;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_regs(16'd16, 16'd4, 16'd64, 16'd640, 16'd0, 16'd0, 16'd640, 16'd400);
                1: set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF, 16'h0001, 16'd0, 16'd65535);
                2: set_regs(16'd0, 16'd8, 16'd64, 16'd320, 16'd0, 16'd0, 16'd100, 16'd100);
                3: set_regs(16'd8, 16'd0, 16'd64, 16'd320, 16'd0, 16'd0, 16'd100, 16'd100);
                4: set_regs(16'hFFFF, 16'hFFE4, 16'hFFFF, 16'd65535, 16'h7FFF, 16'h7FFF,
                            16'd65535, 16'd65535);
                default: begin
                    rand_w = $urandom_range(1, 16);
                    rand_h = $urandom_range(1, rand_w > 4 ? 64 / rand_w : 16);
                    set_regs(16'(rand_w), 16'(rand_h),
                             16'($urandom_range(1, 127)), 16'($urandom_range(1, 65535)),
                             16'($urandom_range(0, 40) - 20), 16'($urandom_range(0, 40) - 20),
                             16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)));
                end
            endcase
            repeat (phase == 2 || phase == 3 ? 5 : 12)
                random_item();
            drain();
        end

        if (mismatches == 0 && write_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### files.f
rtl/ctsb_pkg.sv
rtl/ctsb_ram.sv
rtl/clipped_tile_stamp_blitter_unit.sv
rtl/ctsb_checker.sv
verif/tb.sv
